/* rtl/four_neighbor_outlier_repair_defines.svh */
// ----------------------------------------------------------------------------
// Four-neighbor outlier repair: assertion macros
// Concurrent checks clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef FOUR_NEIGHBOR_OUTLIER_REPAIR_DEFINES_SVH
`define FOUR_NEIGHBOR_OUTLIER_REPAIR_DEFINES_SVH

// same-cycle implication
`define FNOR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FNOR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/fnor_pkg.sv */
// ----------------------------------------------------------------------------
// fnor_pkg
// Shared widths, register indexes, neighbor slots and types of the repair block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fnor_pkg;

   localparam int unsigned PIX_W            = 8;
   localparam int unsigned ROW_W            = 10;
   localparam int unsigned ROWS_CFG_W       = 11;
   localparam int unsigned COLS_CFG_W       = 7;
   localparam int unsigned CSR_DATA_W       = 11;
   localparam int unsigned CSR_IDX_W        = 2;
   localparam int unsigned MAX_COLS_DEFAULT = 64;

   localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = ROWS_CFG_W'(20);
   localparam logic [COLS_CFG_W-1:0] COLS_RESET = COLS_CFG_W'(30);
   localparam logic [ROWS_CFG_W-1:0] ROWS_MIN   = ROWS_CFG_W'(2);
   localparam logic [ROWS_CFG_W-1:0] ROWS_MAX   = ROWS_CFG_W'(1024);
   localparam int unsigned           COLS_MIN   = 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_IDX = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_IDX = CSR_IDX_W'(1);

   // neighbor slots
   localparam int unsigned NB_COUNT = 4;
   localparam int unsigned NB_UP    = 0;
   localparam int unsigned NB_RIGHT = 1;
   localparam int unsigned NB_DOWN  = 2;
   localparam int unsigned NB_LEFT  = 3;

   // sum of up to four pixels, and divide-by-three by reciprocal
   localparam int unsigned SUM_W       = PIX_W + 2;
   localparam int unsigned DIV3_SHIFT  = SUM_W + 2;
   localparam int unsigned PROD_W      = SUM_W + DIV3_SHIFT;
   localparam longint unsigned DIV3_MULT = ((64'd1 << DIV3_SHIFT) + 64'd2) / 64'd3;

   typedef struct packed {
      logic row_gt0;
      logic row_gt1;
      logic last_row;
      logic col_gt0;
      logic col_gt1;
      logic last_col;
   } item_flags_type;

   // one column of the line memory: rows two back and one back
   typedef struct packed {
      logic [PIX_W-1:0] upper;
      logic [PIX_W-1:0] middle;
   } line_entry_type;

   typedef struct packed {
      logic [PIX_W-1:0]                center;
      logic [NB_COUNT-1:0][PIX_W-1:0]  nb;
      logic [NB_COUNT-1:0]             has;
   } window_type;

   typedef struct packed {
      logic [PIX_W-1:0] value;
      logic             replaced;
   } result_type;

endpackage

/* rtl/four_neighbor_outlier_repair.sv */
// ----------------------------------------------------------------------------
// four_neighbor_outlier_repair
// The result for pixel (r-1, c) passes the item and output registers after (r, c) is accepted.
// Throughput: one pixel per cycle unless the output stalls; a last-row pixel is held until
// each result it causes (up to three) is sent, due to the single evaluation unit feeding the output register.
// Reset (synchronous, active high) clears handshakes, position and sets 20 x 30;
// the line memory is not cleared and is filled by the frame's first row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "four_neighbor_outlier_repair_defines.svh"

module four_neighbor_outlier_repair
   import fnor_pkg::*;
#(
   parameter int unsigned MAX_COLS = MAX_COLS_DEFAULT,
   localparam int unsigned COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [PIX_W-1:0]      req_pixel_in,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [PIX_W-1:0]      rsp_pixel_out,
   output logic                  rsp_replaced,
   output logic                  rsp_run_last,
   output logic                  rsp_frame_end,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int unsigned CNT_W = $clog2(MAX_COLS + 1);
   localparam int unsigned CMP_W = (CNT_W > COLS_CFG_W) ? CNT_W : COLS_CFG_W;

   // pending result slots of the held pixel
   localparam int unsigned SLOT_MID      = 0;
   localparam int unsigned SLOT_LOW_PREV = 1;
   localparam int unsigned SLOT_LOW_CUR  = 2;

   logic [ROWS_CFG_W-1:0] rows_cfg_ff, rows_cfg_in;
   logic [COLS_CFG_W-1:0] cols_cfg_ff, cols_cfg_in;
   logic [ROW_W-1:0]      row_ff, row_in;
   logic [COL_W-1:0]      col_ff, col_in;

   logic [ROWS_CFG_W-1:0] eff_rows;
   logic [CNT_W-1:0]      eff_cols;
   logic [CMP_W-1:0]      cols_ext;
   item_flags_type        flags;
   logic [COL_W-1:0]      rd_addr;

   logic                  b_valid_ff, b_valid_in;
   logic [2:0]            pend_ff, pend_in;
   logic [PIX_W-1:0]      b_pix_ff;
   logic [COL_W-1:0]      b_col_ff;
   item_flags_type        b_flags_ff;
   line_entry_type        cur_ff;
   logic [PIX_W-1:0]      prev_mid_ff;
   logic [PIX_W-1:0]      low_prev_ff;
   logic [PIX_W-1:0]      low_prev2_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]      rsp_pixel_ff;
   logic                  rsp_replaced_ff;
   logic                  rsp_run_last_ff;
   logic                  rsp_frame_end_ff;

   line_entry_type        rd_entry;
   line_entry_type        wr_entry;
   window_type            win;
   result_type            res;
   logic [2:0]            sel;
   logic [2:0]            pend_rest;
   logic                  out_free;
   logic                  emit;
   logic                  b_leave;
   logic                  accept;

   // ------------------------------------------------------------------
   // frame geometry
   // ------------------------------------------------------------------
   always_comb begin
      if (rows_cfg_ff < ROWS_MIN) begin
         eff_rows = ROWS_MIN;
      end else if (rows_cfg_ff > ROWS_MAX) begin
         eff_rows = ROWS_MAX;
      end else begin
         eff_rows = rows_cfg_ff;
      end
   end

   assign cols_ext = CMP_W'(cols_cfg_ff);

   always_comb begin
      if (cols_ext < CMP_W'(COLS_MIN)) begin
         eff_cols = CNT_W'(COLS_MIN);
      end else if (cols_ext > CMP_W'(MAX_COLS)) begin
         eff_cols = CNT_W'(MAX_COLS);
      end else begin
         eff_cols = CNT_W'(cols_ext);
      end
   end

   assign flags.row_gt0  = (row_ff != '0);
   assign flags.row_gt1  = (row_ff > ROW_W'(1));
   assign flags.last_row = ({1'b0, row_ff} == (eff_rows - ROWS_CFG_W'(1)));
   assign flags.col_gt0  = (col_ff != '0);
   assign flags.col_gt1  = (CNT_W'(col_ff) > CNT_W'(1));
   assign flags.last_col = (CNT_W'(col_ff) == (eff_cols - CNT_W'(1)));

   // fetch the right neighbor's column; the row's last pixel fetches column 0
   assign rd_addr = flags.last_col ? '0 : (col_ff + COL_W'(1));

   // ------------------------------------------------------------------
   // handshake and result sequencing
   // ------------------------------------------------------------------
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      win = '0;
      sel = '0;
      priority if (pend_ff[SLOT_MID]) begin
         sel[SLOT_MID]       = 1'b1;
         win.center          = cur_ff.middle;
         win.nb[NB_UP]       = cur_ff.upper;
         win.has[NB_UP]      = b_flags_ff.row_gt1;
         win.nb[NB_RIGHT]    = rd_entry.middle;
         win.has[NB_RIGHT]   = !b_flags_ff.last_col;
         win.nb[NB_DOWN]     = b_pix_ff;
         win.has[NB_DOWN]    = 1'b1;
         win.nb[NB_LEFT]     = prev_mid_ff;
         win.has[NB_LEFT]    = b_flags_ff.col_gt0;
      end else if (pend_ff[SLOT_LOW_PREV]) begin
         sel[SLOT_LOW_PREV]  = 1'b1;
         win.center          = low_prev_ff;
         win.nb[NB_UP]       = prev_mid_ff;
         win.has[NB_UP]      = 1'b1;
         win.nb[NB_RIGHT]    = b_pix_ff;
         win.has[NB_RIGHT]   = 1'b1;
         win.nb[NB_LEFT]     = low_prev2_ff;
         win.has[NB_LEFT]    = b_flags_ff.col_gt1;
      end else if (pend_ff[SLOT_LOW_CUR]) begin
         sel[SLOT_LOW_CUR]   = 1'b1;
         win.center          = b_pix_ff;
         win.nb[NB_UP]       = cur_ff.middle;
         win.has[NB_UP]      = 1'b1;
         win.nb[NB_LEFT]     = low_prev_ff;
         win.has[NB_LEFT]    = 1'b1;
      end else begin
         // nothing pending: hold the idle window
      end
   end

   fnor_eval u_eval (
      .win (win),
      .res (res)
   );

   assign pend_rest = pend_ff & ~sel;
   assign emit      = b_valid_ff && (pend_ff != '0) && out_free;
   assign b_leave   = b_valid_ff && ((pend_ff == '0) || (emit && (pend_rest == '0)));
   assign req_ready = !b_valid_ff || b_leave;
   assign accept    = req_valid && req_ready;

   always_comb begin
      pend_in = pend_ff;
      pend_in[SLOT_MID]      = flags.row_gt0;
      pend_in[SLOT_LOW_PREV] = flags.last_row && flags.col_gt0;
      pend_in[SLOT_LOW_CUR]  = flags.last_row && flags.last_col;
      if (!accept) begin
         pend_in = emit ? pend_rest : pend_ff;
      end
   end

   assign b_valid_in   = accept || (b_valid_ff && !b_leave);
   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);

   // ------------------------------------------------------------------
   // configuration and position
   // ------------------------------------------------------------------
   always_comb begin
      rows_cfg_in = rows_cfg_ff;
      cols_cfg_in = cols_cfg_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      if (accept) begin
         if (flags.last_col) begin
            col_in = '0;
            row_in = flags.last_row ? '0 : (row_ff + ROW_W'(1));
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
      // a write to the rows or columns register restarts the frame
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ROWS_IDX: begin
               rows_cfg_in = csr_wdata[ROWS_CFG_W-1:0];
               row_in      = '0;
               col_in      = '0;
            end
            CSR_COLS_IDX: begin
               cols_cfg_in = csr_wdata[COLS_CFG_W-1:0];
               row_in      = '0;
               col_in      = '0;
            end
            default: begin
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_cfg_ff  <= ROWS_RESET;
         cols_cfg_ff  <= COLS_RESET;
         row_ff       <= '0;
         col_ff       <= '0;
         b_valid_ff   <= 1'b0;
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rows_cfg_ff  <= rows_cfg_in;
         cols_cfg_ff  <= cols_cfg_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         b_valid_ff   <= b_valid_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         // shift the row history by one column
         b_pix_ff     <= req_pixel_in;
         b_col_ff     <= col_ff;
         b_flags_ff   <= flags;
         cur_ff       <= rd_entry;
         prev_mid_ff  <= cur_ff.middle;
         low_prev_ff  <= b_pix_ff;
         low_prev2_ff <= low_prev_ff;
      end
      if (emit) begin
         rsp_pixel_ff     <= res.value;
         rsp_replaced_ff  <= res.replaced;
         rsp_run_last_ff  <= (pend_rest == '0);
         rsp_frame_end_ff <= sel[SLOT_LOW_CUR];
      end
   end

   // ------------------------------------------------------------------
   // line memory: retire the column as {row one back, this row}
   // ------------------------------------------------------------------
   assign wr_entry.upper  = cur_ff.middle;
   assign wr_entry.middle = b_pix_ff;

   fnor_line_mem #(
      .DEPTH (MAX_COLS)
   ) u_line_mem (
      .clock   (clock),
      .wr_en   (b_leave),
      .wr_addr (b_col_ff),
      .wr_data (wr_entry),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_out = rsp_pixel_ff;
   assign rsp_replaced  = rsp_replaced_ff;
   assign rsp_run_last  = rsp_run_last_ff;
   assign rsp_frame_end = rsp_frame_end_ff;

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   `FNOR_ASSERT_NOW(a_frame_end_closes_run, rsp_valid_ff && rsp_frame_end_ff, rsp_run_last_ff, "frame end result not last of its item")
   `FNOR_ASSERT_NOW(a_no_accept_with_backlog, b_valid_ff && ($countones(pend_ff) > 1), !req_ready, "item accepted while results still pending")
   `FNOR_ASSERT_NEXT(a_item_held_until_run_last, emit && (pend_rest != '0), b_valid_ff && (pend_ff == $past(pend_rest)), "held item lost before its last result")

endmodule

/* rtl/fnor_line_mem.sv */
// ----------------------------------------------------------------------------
// fnor_line_mem
// Column-packed line memory, one write and one registered read per cycle,
// with the write forwarded to a read of the same column in the same cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fnor_line_mem
   import fnor_pkg::*;
#(
   parameter int unsigned DEPTH = MAX_COLS_DEFAULT,
   localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_W-1:0]     wr_addr,
   input  line_entry_type        wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_W-1:0]     rd_addr,
   output line_entry_type        rd_data
);

   line_entry_type mem_ff [DEPTH];
   line_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         // forward the column being retired this cycle
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/fnor_eval.sv */
// ----------------------------------------------------------------------------
// fnor_eval
// Keep-or-replace decision for one pixel from its existing neighbors.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fnor_eval
   import fnor_pkg::*;
(
   input  window_type win,
   output result_type res
);

   logic [SUM_W-1:0]  sum;
   logic [2:0]        cnt;
   logic              keep;
   logic [SUM_W-1:0]  sum_p1;
   logic [SUM_W-1:0]  sum_p2;
   logic [PROD_W-1:0] prod;
   logic [PIX_W-1:0]  avg;
   logic              close_any;

   always_comb begin
      sum  = '0;
      cnt  = '0;
      keep = 1'b0;
      for (int i = 0; i < NB_COUNT; i++) begin
         if (win.has[i]) begin
            sum = sum + SUM_W'(win.nb[i]);
            cnt = cnt + 3'd1;
            if (({1'b0, win.nb[i]} == {1'b0, win.center}) ||
                ({1'b0, win.nb[i]} == ({1'b0, win.center} + (PIX_W + 1)'(1))) ||
                ({1'b0, win.center} == ({1'b0, win.nb[i]} + (PIX_W + 1)'(1)))) begin
               keep = 1'b1;
            end
         end
      end
   end

   // floor((2*sum + n) / (2*n)) folds to (sum + n/2) / n for n in 1..4
   assign sum_p1 = sum + SUM_W'(1);
   assign sum_p2 = sum + SUM_W'(2);
   assign prod   = PROD_W'(sum_p1) * PROD_W'(DIV3_MULT);

   always_comb begin
      unique case (cnt)
         3'd1:    avg = sum[PIX_W-1:0];
         3'd2:    avg = sum_p1[PIX_W:1];
         3'd3:    avg = prod[DIV3_SHIFT +: PIX_W];
         3'd4:    avg = sum_p2[PIX_W+1:2];
         default: avg = win.center;
      endcase
   end

   assign close_any    = keep || (cnt == 3'd0);
   assign res.replaced = !close_any;
   assign res.value    = close_any ? win.center : avg;

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// Four-neighbor outlier repair testbench
// Streams frames of pixels through the block under several frame sizes and
// compares every result against a line-buffer predictor kept in a scoreboard.
// Both handshakes idle in random bursts, and the receiver holds off once for
// a long stretch so the block fills up and stalls its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import fnor_pkg::*;

   localparam int unsigned MAX_COLS      = MAX_COLS_DEFAULT;
   localparam int unsigned RANDOM_TARGET = 360;
   localparam int unsigned HOLD_AT       = 40;
   localparam int unsigned HOLD_CYCLES   = 300;
   localparam int unsigned DRAIN_CYCLES  = 8;

   // indexes the block ignores
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_LO = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_HI = CSR_IDX_W'(3);

   typedef enum int unsigned {TEX_SMOOTH, TEX_NOISE, TEX_SPIKY} texture_type;

   typedef struct packed {
      logic [PIX_W-1:0] level;
      logic             replaced;
      logic             run_last;
      logic             frame_end;
   } pixel_result_type;

   class repair_scoreboard;
      logic [ROWS_CFG_W-1:0] rows_reg;
      logic [COLS_CFG_W-1:0] cols_reg;
      logic [PIX_W-1:0]      upper_row  [MAX_COLS];
      logic [PIX_W-1:0]      middle_row [MAX_COLS];
      logic [PIX_W-1:0]      lower_row  [MAX_COLS];
      int unsigned           row_pos;
      int unsigned           col_pos;
      pixel_result_type      pending [$];
      int unsigned           checked;
      int unsigned           errors;

      function new();
         rows_reg   = ROWS_RESET;
         cols_reg   = COLS_RESET;
         upper_row  = '{default: '0};
         middle_row = '{default: '0};
         lower_row  = '{default: '0};
         row_pos    = 0;
         col_pos    = 0;
         checked    = 0;
         errors     = 0;
      endfunction

      function int unsigned eff_rows();
         int unsigned r;
         r = rows_reg;
         if (r < 2) r = 2;
         if (r > 1024) r = 1024;
         return r;
      endfunction

      function int unsigned eff_cols();
         int unsigned c;
         c = cols_reg;
         if (c < COLS_MIN) c = COLS_MIN;
         if (c > MAX_COLS) c = MAX_COLS;
         return c;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_ROWS_IDX) begin
            rows_reg = data[ROWS_CFG_W-1:0];
         end else if (idx == CSR_COLS_IDX) begin
            cols_reg = data[COLS_CFG_W-1:0];
         end else begin
            return;
         end
         // any real write restarts the frame
         row_pos = 0;
         col_pos = 0;
      endfunction

      function pixel_result_type repair_pixel(logic [PIX_W-1:0] center,
                                              logic [NB_COUNT-1:0][PIX_W-1:0] nb,
                                              logic [NB_COUNT-1:0] has);
         pixel_result_type res;
         int unsigned      sum, n, diff;
         bit               keep;
         sum  = 0;
         n    = 0;
         keep = 1'b0;
         for (int i = 0; i < NB_COUNT; i++) begin
            if (has[i]) begin
               diff = (nb[i] > center) ? nb[i] - center : center - nb[i];
               if (diff <= 1) keep = 1'b1;
               sum += nb[i];
               n++;
            end
         end
         res = '0;
         res.level = center;
         if (!keep && n != 0) begin
            res.level    = PIX_W'((2 * sum + n) / (2 * n));
            res.replaced = 1'b1;
         end
         return res;
      endfunction

      function void note_pixel(logic [PIX_W-1:0] px);
         int unsigned                    nrows, ncols, r, c;
         logic [NB_COUNT-1:0][PIX_W-1:0] nb;
         logic [NB_COUNT-1:0]            has;
         pixel_result_type               outs [3];
         int                             k;
         nrows = eff_rows();
         ncols = eff_cols();
         r = row_pos;
         c = col_pos;
         k = 0;
         if (r >= nrows) r = 0;
         if (c >= ncols) c = 0;
         lower_row[c] = px;
         // middle row pixel in the same column
         if (r >= 1) begin
            nb = '0;
            has = '0;
            has[NB_UP] = (r >= 2);
            if (has[NB_UP]) nb[NB_UP] = upper_row[c];
            has[NB_RIGHT] = (c + 1 < ncols);
            if (has[NB_RIGHT]) nb[NB_RIGHT] = middle_row[c + 1];
            has[NB_DOWN] = 1'b1;
            nb[NB_DOWN]  = lower_row[c];
            has[NB_LEFT] = (c >= 1);
            if (has[NB_LEFT]) nb[NB_LEFT] = middle_row[c - 1];
            outs[k] = repair_pixel(middle_row[c], nb, has);
            k++;
         end
         // the last row drains behind its own input
         if (r == nrows - 1) begin
            if (c >= 1) begin
               nb = '0;
               has = '0;
               has[NB_UP]    = 1'b1;
               nb[NB_UP]     = middle_row[c - 1];
               has[NB_RIGHT] = 1'b1;
               nb[NB_RIGHT]  = lower_row[c];
               has[NB_LEFT]  = (c >= 2);
               if (has[NB_LEFT]) nb[NB_LEFT] = lower_row[c - 2];
               outs[k] = repair_pixel(lower_row[c - 1], nb, has);
               k++;
            end
            if (c == ncols - 1) begin
               nb = '0;
               has = '0;
               has[NB_UP]   = 1'b1;
               nb[NB_UP]    = middle_row[c];
               has[NB_LEFT] = 1'b1;
               nb[NB_LEFT]  = lower_row[c - 1];
               outs[k] = repair_pixel(lower_row[c], nb, has);
               outs[k].frame_end = 1'b1;
               k++;
            end
         end
         if (k > 0) outs[k - 1].run_last = 1'b1;
         for (int i = 0; i < k; i++) pending.push_back(outs[i]);
         c++;
         if (c == ncols) begin
            c = 0;
            upper_row  = middle_row;
            middle_row = lower_row;
            r++;
            if (r == nrows) r = 0;
         end
         row_pos = r;
         col_pos = c;
      endfunction

      function void check_result(logic [PIX_W-1:0] level, logic repl, logic last,
                                 logic fend);
         pixel_result_type want;
         checked++;
         if (pending.size() == 0) begin
            $error("unexpected result: pixel_out %0d replaced %0b", level, repl);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (level !== want.level) begin
            $error("pixel_out expected %0d actual %0d", want.level, level);
            errors++;
         end
         if (repl !== want.replaced) begin
            $error("replaced expected %0b actual %0b", want.replaced, repl);
            errors++;
         end
         if (last !== want.run_last) begin
            $error("run_last expected %0b actual %0b", want.run_last, last);
            errors++;
         end
         if (fend !== want.frame_end) begin
            $error("frame_end expected %0b actual %0b", want.frame_end, fend);
            errors++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [PIX_W-1:0]      req_pixel_in = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [PIX_W-1:0]      rsp_pixel_out;
   logic                  rsp_replaced;
   logic                  rsp_run_last;
   logic                  rsp_frame_end;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   repair_scoreboard board = new();
   bit               idle_on = 1'b1;
   int unsigned      random_items = 0;

   // all four corners are outliers
   logic [PIX_W-1:0] corner_frame [4] = '{8'd0, 8'd255, 8'd255, 8'd0};
   // center with four neighbors, edges with three, a kept pixel next to a replaced one
   logic [PIX_W-1:0] cross_frame [9] = '{8'd7, 8'd9, 8'd8, 8'd10, 8'd200, 8'd12,
                                         8'd255, 8'd0, 8'd254};
   // half-way mean at a corner, neighbors one apart, the top value
   logic [PIX_W-1:0] round_frame [9] = '{8'd100, 8'd3, 8'd50, 8'd4, 8'd128, 8'd127,
                                         8'd1, 8'd255, 8'd2};

   four_neighbor_outlier_repair dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_pixel_in  (req_pixel_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_pixel_out (rsp_pixel_out),
      .rsp_replaced  (rsp_replaced),
      .rsp_run_last  (rsp_run_last),
      .rsp_frame_end (rsp_frame_end),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always #1 clock = ~clock;

   initial begin
      #400000;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic logic [PIX_W-1:0] next_level(texture_type tex, int unsigned base);
      case (tex)
         TEX_NOISE: return PIX_W'($urandom);
         TEX_SPIKY: if ($urandom_range(0, 5) == 0) return PIX_W'($urandom);
         default: ;
      endcase
      return PIX_W'(base + $urandom_range(0, 2));
   endfunction

   task automatic send_pixel(input logic [PIX_W-1:0] px);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_pixel_in <= px;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_pixel(px);
   endtask

   task automatic pixel_run(input int unsigned count, input texture_type tex,
                            input int unsigned base);
      repeat (count) send_pixel(next_level(tex, base));
   endtask

   // drop valid, let every result drain, then give the block time to settle
   task automatic quiesce();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      board.write_reg(idx, data);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_phase();
      int unsigned pick, rows_val, cols_val, frame_len, count;
      idle_on = (random_items + 60 < RANDOM_TARGET);
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
         // ignored index: the frame carries on where it stopped
         write_csr((pick == 0) ? CSR_UNUSED_LO : CSR_UNUSED_HI, CSR_DATA_W'($urandom));
         count = $urandom_range(10, 60);
      end else begin
         case ($urandom_range(0, 9))
            0:       rows_val = $urandom_range(0, 1);
            1:       rows_val = $urandom_range(1025, 2047);
            2, 3:    rows_val = $urandom_range(7, 40);
            default: rows_val = $urandom_range(2, 6);
         endcase
         case ($urandom_range(0, 9))
            0:       cols_val = $urandom_range(0, 1);
            1:       cols_val = $urandom_range(65, 127);
            2, 3:    cols_val = $urandom_range(0, 2047);
            default: cols_val = $urandom_range(2, MAX_COLS);
         endcase
         if (pick != 4 && pick != 5) write_csr(CSR_ROWS_IDX, CSR_DATA_W'(rows_val));
         if (pick != 2 && pick != 3) write_csr(CSR_COLS_IDX, CSR_DATA_W'(cols_val));
         frame_len = board.eff_rows() * board.eff_cols();
         if (frame_len > 240) count = $urandom_range(20, 120);
         else if ($urandom_range(0, 4) == 0) count = $urandom_range(1, frame_len - 1);
         else if (frame_len <= 100) count = frame_len * $urandom_range(1, 2);
         else count = frame_len;
      end
      // stop at the item budget
      if (count > RANDOM_TARGET - random_items) count = RANDOM_TARGET - random_items;
      pixel_run(count, texture_type'($urandom_range(0, 2)), $urandom_range(0, 253));
      random_items += count;
      quiesce();
   endtask

   // receiver: random stalls, one long hold-off early in the run
   initial begin : receive_side
      int unsigned stall_left;
      bit          held;
      stall_left = 0;
      held       = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            board.check_result(rsp_pixel_out, rsp_replaced, rsp_run_last, rsp_frame_end);
         if (!held && board.checked >= HOLD_AT) begin
            held       = 1'b1;
            stall_left = HOLD_CYCLES;
         end else if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 17);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // frame size left by reset
      pixel_run(45, TEX_NOISE, 0);
      quiesce();

      write_csr(CSR_ROWS_IDX, CSR_DATA_W'(2));
      write_csr(CSR_COLS_IDX, CSR_DATA_W'(2));
      foreach (corner_frame[i]) send_pixel(corner_frame[i]);
      quiesce();
      write_csr(CSR_ROWS_IDX, CSR_DATA_W'(3));
      write_csr(CSR_COLS_IDX, CSR_DATA_W'(3));
      foreach (cross_frame[i]) send_pixel(cross_frame[i]);
      foreach (round_frame[i]) send_pixel(round_frame[i]);
      quiesce();

      // widest row, then tallest frame cut short
      write_csr(CSR_ROWS_IDX, CSR_DATA_W'(2));
      write_csr(CSR_COLS_IDX, CSR_DATA_W'(MAX_COLS));
      pixel_run(2 * MAX_COLS, TEX_SPIKY, $urandom_range(0, 253));
      quiesce();
      write_csr(CSR_ROWS_IDX, CSR_DATA_W'(1024));
      write_csr(CSR_COLS_IDX, CSR_DATA_W'(2));
      pixel_run(60, TEX_SMOOTH, $urandom_range(0, 253));
      quiesce();
      random_items = 45 + $size(corner_frame) + $size(cross_frame) + $size(round_frame)
                     + 2 * MAX_COLS + 60;

      while (random_items < RANDOM_TARGET) random_phase();

      quiesce();
      if (board.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+rtl
rtl/fnor_pkg.sv
rtl/fnor_line_mem.sv
rtl/fnor_eval.sv
rtl/four_neighbor_outlier_repair.sv
bench/testbench.sv
